/* src/tcs_pkg.sv */
package tcs_pkg;

   localparam int DEPTH       = 1024;
   localparam int CHANNELS    = 4;
   localparam int SAMPLE_BITS = 16;

   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS    = ADDR_BITS + 1;
   localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MASK_BITS   = CHANNELS;

   // A channel may fire once this many samples were held before the new one.
   localparam int HELD_CHECK_MIN = 4;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_RISE   = 2'd1,
      MODE_FALL   = 2'd2,
      MODE_EITHER = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_DECIMATION = 3'd0,
      REG_TRIG_MODE  = 3'd1,
      REG_TRIG_LEVEL = 3'd2,
      REG_TRIG_MASK  = 3'd3,
      REG_POST_TICKS = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic                          store;
      logic                          start;
      logic                          check;
      mode_type                      mode;
      logic signed [SAMPLE_BITS-1:0] level;
      logic [ADDR_BITS-1:0]          wr_addr;
      logic                          rd_en;
      logic [ADDR_BITS-1:0]          rd_addr;
   } lane_ctrl_type;

   function automatic logic edge_hit(input logic signed [SAMPLE_BITS-1:0] prev,
                                     input logic signed [SAMPLE_BITS-1:0] cur,
                                     input logic signed [SAMPLE_BITS-1:0] level,
                                     input mode_type mode);
      logic up;
      logic down;
      logic hit;
      up   = (prev < level) && (cur >= level);
      down = (prev > level) && (cur <= level);
      unique case (mode)
         MODE_RISE:   hit = up;
         MODE_FALL:   hit = down;
         MODE_EITHER: hit = up || down;
         default:     hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

/* src/tcs_lane.sv */
module tcs_lane
   import tcs_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  lane_ctrl_type                 ctrl,
   input  logic                          enable,
   input  logic                          dec_en,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic                          hit,
   output logic [CNT_BITS-1:0]           offset_next,
   output logic signed [SAMPLE_BITS-1:0] rd_data
);

   logic signed [SAMPLE_BITS-1:0] sample_mem [DEPTH];
   logic signed [SAMPLE_BITS-1:0] prev_ff;
   logic [CNT_BITS-1:0]           offset_ff;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   // The edge is checked against the last stored sample of this channel.
   assign hit = ctrl.check && enable && edge_hit(prev_ff, sample, ctrl.level, ctrl.mode);

   always_comb begin
      offset_next = offset_ff;
      if (ctrl.start) begin
         offset_next = CNT_BITS'(DEPTH);
      end else if (dec_en && (offset_ff != '0)) begin
         offset_next = offset_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         offset_ff <= CNT_BITS'(DEPTH);
      end else begin
         offset_ff <= offset_next;
         if (ctrl.store) begin
            prev_ff <= sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.store) begin
         sample_mem[ctrl.wr_addr] <= sample;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= sample_mem[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tcs_merge.sv */
module tcs_merge
   import tcs_pkg::*;
(
   input  logic                store,
   input  logic                fired,
   input  logic [CHANNELS-1:0] hit,
   output logic                fire_now,
   output logic [CHANNELS-1:0] dec_en
);

   logic [CHANNELS:0] seen;

   // Channels after the first firing one in the same tick already count down.
   always_comb begin
      seen[0] = fired;
      for (int c = 0; c < CHANNELS; c++) begin
         dec_en[c]  = store && seen[c];
         seen[c+1]  = seen[c] || hit[c];
      end
   end

   assign fire_now = store && !fired && (|hit);

endmodule

/* src/triggered_capture_scope.sv */
// Single-shot four-channel capture scope with an edge trigger.
// The req channel carries one word per command: a tick with one sample per
// channel, start, stop or read (command in req_tuser). Every accepted word
// produces exactly one rsp word with the read value (zero unless an in-range
// read), the fill count, the trigger position of the selected channel and the
// running, triggered and complete flags as they stand after that command.
// Throughput is one word per clock unless stalled; each channel has its own lane
// with a ring memory, and the lanes' edge detectors are merged in channel order.
// After acceptance the state update and the registered ring read land in the
// read stage, then the word moves to the output register and rsp_tvalid.
// When the receiver stalls, one word waits in the output register and one in
// the read stage; req_tready drops only when both are full and rsp_tready is low.
// Reset clears all capture state, loads the register defaults and returns the
// block to idle and disarmed; no clearing pass runs over the rings, since reads
// never reach entries beyond the fill count. Configuration is written through
// the csr port by the user only while idle; the block does not enforce this.
module triggered_capture_scope
   import tcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata from bit 0: sample_ch0, sample_ch1, sample_ch2, sample_ch3,
   // read_channel, read_index, zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,
   // req_tuser from bit 0: cmd
   input  logic [1:0]  req_tuser,
   // rsp_tdata from bit 0: read_value, fill_count, trigger_position,
   // running, triggered, complete, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers.
   logic [15:0]                   decimation_ff;
   mode_type                      trig_mode_ff;
   logic signed [SAMPLE_BITS-1:0] trig_level_ff;
   logic [MASK_BITS-1:0]          trig_mask_ff;
   logic [15:0]                   post_ticks_ff;

   reg_index_type csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         decimation_ff <= 16'd1;
         trig_mode_ff  <= MODE_NONE;
         trig_level_ff <= '0;
         trig_mask_ff  <= MASK_BITS'(1);
         post_ticks_ff <= 16'd1000;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DECIMATION: decimation_ff <= csr_pwdata[15:0];
            REG_TRIG_MODE:  trig_mode_ff  <= mode_type'(csr_pwdata[1:0]);
            REG_TRIG_LEVEL: trig_level_ff <= csr_pwdata[SAMPLE_BITS-1:0];
            REG_TRIG_MASK:  trig_mask_ff  <= csr_pwdata[MASK_BITS-1:0];
            REG_POST_TICKS: post_ticks_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DECIMATION: csr_prdata = {16'd0, decimation_ff};
         REG_TRIG_MODE:  csr_prdata = {30'd0, trig_mode_ff};
         REG_TRIG_LEVEL: csr_prdata = {{(32-SAMPLE_BITS){1'b0}}, trig_level_ff};
         REG_TRIG_MASK:  csr_prdata = {{(32-MASK_BITS){1'b0}}, trig_mask_ff};
         REG_POST_TICKS: csr_prdata = {16'd0, post_ticks_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Unpack the incoming word.
   localparam int RCH_LSB = CHANNELS * SAMPLE_BITS;
   localparam int RIX_LSB = RCH_LSB + 3;

   cmd_type                       cmd;
   logic [2:0]                    read_channel;
   logic [ADDR_BITS-1:0]          read_index;
   logic signed [SAMPLE_BITS-1:0] samples [CHANNELS];

   assign cmd          = cmd_type'(req_tuser);
   assign read_channel = req_tdata[RCH_LSB +: 3];
   assign read_index   = req_tdata[RIX_LSB +: ADDR_BITS];

   // Capture state.
   logic [ADDR_BITS-1:0] wp_ff,      wp_in;
   logic [CNT_BITS-1:0]  held_ff,    held_in;
   logic [15:0]          dec_cnt_ff, dec_cnt_in;
   logic [15:0]          post_ff,    post_in;
   logic                 armed_ff,   armed_in;
   logic                 fired_ff,   fired_in;
   logic                 done_ff,    done_in;

   logic accept;
   logic post_stop;
   logic skip;
   logic store;
   logic fire_now;
   logic start;
   logic read_ok;

   logic [CHANNELS-1:0]           hit;
   logic [CHANNELS-1:0]           dec_en;
   logic [CNT_BITS-1:0]           offset_next [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] lane_rd     [CHANNELS];
   lane_ctrl_type                 lane_ctrl;

   assign accept    = req_tvalid && req_tready;
   assign post_stop = fired_ff && (post_ff >= post_ticks_ff);
   assign skip      = dec_cnt_ff < decimation_ff;
   assign store     = accept && (cmd == CMD_TICK) && armed_ff && !post_stop && !skip;
   assign start     = accept && (cmd == CMD_START);
   assign read_ok   = (read_channel < 3'(CHANNELS)) && (CNT_BITS'(read_index) < held_ff);

   // Oldest held sample sits held_ff entries behind the write pointer.
   always_comb begin
      lane_ctrl.store   = store;
      lane_ctrl.start   = start;
      lane_ctrl.check   = !fired_ff && (held_ff >= CNT_BITS'(HELD_CHECK_MIN));
      lane_ctrl.mode    = trig_mode_ff;
      lane_ctrl.level   = trig_level_ff;
      lane_ctrl.wr_addr = wp_ff;
      lane_ctrl.rd_en   = accept && (cmd == CMD_READ);
      lane_ctrl.rd_addr = wp_ff - held_ff[ADDR_BITS-1:0] + read_index;
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      assign samples[c] = req_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];

      tcs_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (lane_ctrl),
         .enable      (trig_mask_ff[c]),
         .dec_en      (dec_en[c]),
         .sample      (samples[c]),
         .hit         (hit[c]),
         .offset_next (offset_next[c]),
         .rd_data     (lane_rd[c])
      );
   end

   tcs_merge u_merge (
      .store    (store),
      .fired    (fired_ff),
      .hit      (hit),
      .fire_now (fire_now),
      .dec_en   (dec_en)
   );

   always_comb begin
      wp_in      = wp_ff;
      held_in    = held_ff;
      dec_cnt_in = dec_cnt_ff;
      post_in    = post_ff;
      armed_in   = armed_ff;
      fired_in   = fired_ff;
      done_in    = done_ff;
      if (accept) begin
         unique case (cmd)
            CMD_TICK: begin
               if (armed_ff) begin
                  if (post_stop) begin
                     armed_in = 1'b0;
                     done_in  = 1'b1;
                  end else begin
                     if (fired_ff && (post_ff != '1)) begin
                        post_in = post_ff + 1'b1;
                     end
                     if (skip) begin
                        dec_cnt_in = dec_cnt_ff + 1'b1;
                     end else begin
                        dec_cnt_in = 16'd1;
                        wp_in      = wp_ff + 1'b1;
                        if (held_ff < CNT_BITS'(DEPTH)) begin
                           held_in = held_ff + 1'b1;
                        end
                        if (fire_now) begin
                           fired_in = 1'b1;
                           post_in  = '0;
                        end
                     end
                  end
               end
            end
            CMD_START: begin
               armed_in = 1'b1;
               fired_in = 1'b0;
               done_in  = 1'b0;
               held_in  = '0;
               wp_in    = '0;
            end
            CMD_STOP: begin
               armed_in = 1'b0;
               done_in  = 1'b1;
            end
            CMD_READ: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         held_ff    <= '0;
         dec_cnt_ff <= 16'd1;
         post_ff    <= '0;
         armed_ff   <= 1'b0;
         fired_ff   <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         held_ff    <= held_in;
         dec_cnt_ff <= dec_cnt_in;
         post_ff    <= post_in;
         armed_ff   <= armed_in;
         fired_ff   <= fired_in;
         done_ff    <= done_in;
      end
   end

   // Read stage: holds the status of the word whose ring read is in flight.
   logic                   s1_valid_ff;
   logic                   s1_read_ok_ff;
   logic [CH_IDX_BITS-1:0] s1_ch_ff;
   logic [CNT_BITS-1:0]    s1_fill_ff;
   logic [CNT_BITS-1:0]    s1_tpos_ff;
   logic                   s1_running_ff;
   logic                   s1_triggered_ff;
   logic                   s1_complete_ff;

   // Output register.
   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_value_ff;
   logic [CNT_BITS-1:0]           out_fill_ff;
   logic [CNT_BITS-1:0]           out_tpos_ff;
   logic                          out_running_ff;
   logic                          out_triggered_ff;
   logic                          out_complete_ff;

   logic                   advance;
   logic [CH_IDX_BITS-1:0] ch_idx;
   logic [CNT_BITS-1:0]    tpos;

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || !out_valid_ff || rsp_tready;
   assign ch_idx     = read_channel[CH_IDX_BITS-1:0];
   assign tpos       = (read_channel < 3'(CHANNELS)) ? offset_next[ch_idx] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_read_ok_ff   <= read_ok && (cmd == CMD_READ);
         s1_ch_ff        <= ch_idx;
         s1_fill_ff      <= held_in;
         s1_tpos_ff      <= tpos;
         s1_running_ff   <= armed_in;
         s1_triggered_ff <= fired_in;
         s1_complete_ff  <= done_in;
      end
      if (advance) begin
         out_value_ff     <= s1_read_ok_ff ? lane_rd[s1_ch_ff] : '0;
         out_fill_ff      <= s1_fill_ff;
         out_tpos_ff      <= s1_tpos_ff;
         out_running_ff   <= s1_running_ff;
         out_triggered_ff <= s1_triggered_ff;
         out_complete_ff  <= s1_complete_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_complete_ff, out_triggered_ff, out_running_ff,
                        out_tpos_ff, out_fill_ff, out_value_ff};

`ifndef SYNTHESIS
   // Start and stop always move armed and complete in opposite directions.
   a_armed_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(armed_ff && done_ff))
      else $error("armed and complete set together");

   // A firing tick restarts the post-trigger count from zero.
   a_fire_clears_post: assert property (@(posedge clock) disable iff (reset)
      fire_now |=> (fired_ff && (post_ff == '0)))
      else $error("trigger fired without clearing the post counter");

   // A word in the read stage is never dropped while the output is stalled.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |=> s1_valid_ff)
      else $error("read stage lost a word during a stall");
`endif

endmodule
